// ===== hdl/rapi_pkg.sv =====
// Package for the reversing actuator pulse interlock.
// Holds widths, operation codes, register indexes, reset values and transaction types.
// Used by every module in hdl/.
package rapi_pkg;

  localparam int TIME_BITS   = 48;
  localparam int OWNER_BITS  = 3;
  localparam int DUR_BITS    = 32;
  localparam int DEAD_BITS   = 16;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [DEAD_BITS-1:0] DEAD_TIME_RESET = 16'd1000;
  localparam logic [DUR_BITS-1:0]  MAX_PULSE_RESET = 32'd120000;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_REQUEST = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_TAKE    = 3'd3,
    OP_BEGIN   = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEAD_TIME = 1'b0,
    REG_MAX_PULSE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]            operation;
    logic                  req_direction;
    logic [DUR_BITS-1:0]   duration_ms;
    logic [OWNER_BITS-1:0] req_owner;
    logic [TIME_BITS-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic                  power_on;
    logic                  dir_open;
    logic                  running;
    logic                  shown_direction;
    logic [OWNER_BITS-1:0] shown_owner;
    logic [DUR_BITS-1:0]   run_elapsed_ms;
    logic [DUR_BITS-1:0]   open_total_ms;
    logic [DUR_BITS-1:0]   close_total_ms;
    logic                  has_moved;
    logic [TIME_BITS-1:0]  last_move_ms;
  } out_item_t;

endpackage

// ===== hdl/reversing_actuator_pulse_interlock_top.sv =====
// Top level of the reversing actuator pulse interlock.
// Holds the configuration registers; instantiates rapi_in_stage and rapi_core.
// Depends on rapi_pkg.
//
//  channel  | handshake            | payload            | direction
//  ---------+----------------------+--------------------+----------
//  in_      | in_valid / in_stall  | in_data (in_item_t)  | input
//  out_     | out_valid / out_stall| out_data (out_item_t)| output
//  cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data  | input
//
// One result transaction per operation, passing through the input register and
// then the result register; one operation per cycle sustained while out_stall
// is low, set by the single pass through the next-state logic between them.
// Synchronous active-low reset clears the interlock state and loads the
// default dead time and maximum pulse. A stalled result blocks the input
// register only once that register also holds an operation.
module reversing_actuator_pulse_interlock_top
  import rapi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [DEAD_BITS-1:0] dead_time_r;
  logic [DUR_BITS-1:0]  max_pulse_r;
  logic                 take;
  logic                 item_valid;
  in_item_t             item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_time_r <= DEAD_TIME_RESET;
      max_pulse_r <= MAX_PULSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEAD_TIME: dead_time_r <= cfg_data[DEAD_BITS-1:0];
        REG_MAX_PULSE: max_pulse_r <= cfg_data[DUR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rapi_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rapi_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .dead_time  (dead_time_r),
    .max_pulse  (max_pulse_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== hdl/rapi_in_stage.sv =====
// Input register of the pulse interlock: captures one operation transaction.
// Depends on rapi_pkg for the input transaction type.
module rapi_in_stage
  import rapi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  in_item_t item_r;

  // Hold the captured item until the core takes it.
  assign in_stall   = valid_r && !take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== hdl/rapi_core.sv =====
// Interlock state, one-pass next-state logic and the result register.
// Depends on rapi_pkg for widths, operation codes and transaction types.
module rapi_core
  import rapi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  in_item_t             item,
  output logic                 take,
  input  logic [DEAD_BITS-1:0] dead_time,
  input  logic [DUR_BITS-1:0]  max_pulse,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  typedef struct packed {
    logic                  power;
    logic                  dir;
    logic                  run_active;
    logic                  run_dir;
    logic                  pend_valid;
    logic                  pend_dir;
    logic                  moved;
    logic [TIME_BITS-1:0]  power_off_time;
    logic [TIME_BITS-1:0]  dir_change_time;
    logic [TIME_BITS-1:0]  run_start;
    logic [TIME_BITS-1:0]  run_end;
    logic [TIME_BITS-1:0]  move_time;
    logic [OWNER_BITS-1:0] run_owner;
    logic [OWNER_BITS-1:0] pend_owner;
    logic [DUR_BITS-1:0]   pend_duration;
    logic [DUR_BITS-1:0]   open_accum;
    logic [DUR_BITS-1:0]   close_accum;
  } st_t;

  st_t       st_r, st_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      fire;

  function automatic logic [DUR_BITS-1:0] sat32(input logic [TIME_BITS-1:0] v);
    return (|v[TIME_BITS-1:DUR_BITS]) ? {DUR_BITS{1'b1}} : v[DUR_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] end_time(input logic [TIME_BITS-1:0] now,
                                                    input logic [DUR_BITS-1:0] dur);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, now} + {{(TIME_BITS+1-DUR_BITS){1'b0}}, dur};
    return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  endfunction

  function automatic logic [DUR_BITS-1:0] sat_add(input logic [DUR_BITS-1:0] a,
                                                  input logic [DUR_BITS-1:0] b);
    logic [DUR_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DUR_BITS] ? {DUR_BITS{1'b1}} : sum[DUR_BITS-1:0];
  endfunction

  function automatic st_t stop_run(input st_t s, input logic [TIME_BITS-1:0] now);
    st_t r;
    logic [DUR_BITS-1:0] ran;
    r   = s;
    ran = sat32(now - s.run_start);
    if (s.run_dir) begin
      r.open_accum = sat_add(s.open_accum, ran);
    end else begin
      r.close_accum = sat_add(s.close_accum, ran);
    end
    r.moved          = 1'b1;
    r.move_time      = now;
    r.power          = 1'b0;
    r.run_active     = 1'b0;
    r.power_off_time = now;
    return r;
  endfunction

  assign take = !out_valid_r || !out_stall;
  assign fire = item_valid && take;

  always_comb begin
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] dead_ext;
    logic [TIME_BITS:0]   back;
    logic                 acc;
    logic [DUR_BITS-1:0]  took_open;
    logic [DUR_BITS-1:0]  took_close;
    now        = item.now_ms;
    dead_ext   = {{(TIME_BITS-DEAD_BITS){1'b0}}, dead_time};
    back       = {1'b0, now} - {1'b0, dead_ext};
    acc        = 1'b0;
    took_open  = '0;
    took_close = '0;
    st_nxt     = st_r;

    unique case (item.operation)
      OP_TICK: begin
        if (st_nxt.run_active) begin
          st_nxt.move_time = now;
          if (now >= st_nxt.run_end) begin
            st_nxt = stop_run(st_nxt, now);
          end
        end
        if (st_nxt.pend_valid && !st_nxt.run_active) begin
          if (st_nxt.dir != st_nxt.pend_dir) begin
            // Switch direction only after the power-off dead time; power stays off.
            if (!st_nxt.power && (now - st_nxt.power_off_time) >= dead_ext) begin
              st_nxt.dir             = st_nxt.pend_dir;
              st_nxt.dir_change_time = now;
            end
          end else if ((now - st_nxt.dir_change_time) >= dead_ext) begin
            st_nxt.power      = 1'b1;
            st_nxt.run_active = 1'b1;
            st_nxt.run_dir    = st_nxt.pend_dir;
            st_nxt.run_start  = now;
            st_nxt.run_end    = end_time(now, st_nxt.pend_duration);
            st_nxt.run_owner  = st_nxt.pend_owner;
            st_nxt.pend_valid = 1'b0;
            st_nxt.moved      = 1'b1;
            st_nxt.move_time  = now;
          end
        end else if (!st_nxt.pend_valid && !st_nxt.run_active && st_nxt.dir &&
                     (now - st_nxt.power_off_time) >= dead_ext) begin
          // Idle: return the direction relay to close.
          st_nxt.dir             = 1'b0;
          st_nxt.dir_change_time = now;
        end
      end
      OP_REQUEST: begin
        if (item.duration_ms != '0 && item.duration_ms <= max_pulse) begin
          acc = 1'b1;
          if (st_nxt.run_active && st_nxt.run_dir == item.req_direction) begin
            st_nxt.run_end   = end_time(now, item.duration_ms);
            st_nxt.run_owner = item.req_owner;
          end else begin
            if (st_nxt.run_active) begin
              st_nxt = stop_run(st_nxt, now);
            end
            st_nxt.pend_valid    = 1'b1;
            st_nxt.pend_dir      = item.req_direction;
            st_nxt.pend_duration = item.duration_ms;
            st_nxt.pend_owner    = item.req_owner;
          end
        end
      end
      OP_CANCEL: begin
        if (st_nxt.run_active) begin
          st_nxt = stop_run(st_nxt, now);
        end
        st_nxt.pend_valid = 1'b0;
      end
      OP_TAKE: begin
        took_open          = st_nxt.open_accum;
        took_close         = st_nxt.close_accum;
        st_nxt.open_accum  = '0;
        st_nxt.close_accum = '0;
      end
      OP_BEGIN: begin
        st_nxt                 = '0;
        st_nxt.power_off_time  = now;
        // Back-date the direction change so a close pulse may start at once.
        st_nxt.dir_change_time = back[TIME_BITS] ? '0 : back[TIME_BITS-1:0];
      end
      default: begin
      end
    endcase

    out_data_nxt.accepted        = acc;
    out_data_nxt.power_on        = st_nxt.power;
    out_data_nxt.dir_open        = st_nxt.dir;
    out_data_nxt.running         = st_nxt.run_active;
    out_data_nxt.shown_direction = st_nxt.run_active ? st_nxt.run_dir :
                                   (st_nxt.pend_valid ? st_nxt.pend_dir : 1'b0);
    out_data_nxt.shown_owner     = st_nxt.run_active ? st_nxt.run_owner :
                                   (st_nxt.pend_valid ? st_nxt.pend_owner : '0);
    out_data_nxt.run_elapsed_ms  = st_nxt.run_active ? sat32(now - st_nxt.run_start) : '0;
    out_data_nxt.open_total_ms   = took_open;
    out_data_nxt.close_total_ms  = took_close;
    out_data_nxt.has_moved       = st_nxt.moved;
    out_data_nxt.last_move_ms    = st_nxt.move_time;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_power_tracks_run: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.power == st_r.run_active)
    else $error("power relay on without a run, or run without power");

  a_run_excludes_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.run_active && st_r.pend_valid))
    else $error("pulse pending while a run is active");

  a_run_dir_matches_relay: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.run_active |-> (st_r.dir == st_r.run_dir))
    else $error("run active with direction relay in the other direction");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("taken operation produced no result");

endmodule
